@@ rtl/core/rua_pkg.sv @@
// Shared types and constants for the rectangle union area sweep.
package rua_pkg;

    // Width of every y coordinate, span and covered length in the tree.
    localparam int SPAN_BITS = 16;
    // Value of the extent register after reset.
    localparam logic [SPAN_BITS-1:0] EXTENT_RESET = 16'h8000;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_RD_ROOT,
        OP_MUL,
        OP_ADD,
        OP_POP,
        OP_DESCEND,
        OP_FIN_RD,
        OP_FIN_CNT,
        OP_FIN_LLEN,
        OP_FIN_WR,
        OP_OUT
    } t_op;

    // Progress of a tree node held on the traversal stack.
    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_op  op;
        logic in_open;
        logic cfg_open;
    } t_cmd;

    typedef struct packed {
        logic   cfg_we;
        logic   in_take;
        logic   clear_last;
        logic   range_ok;
        logic   stack_empty;
        t_phase top_phase;
        logic   top_full;
        logic   top_disjoint;
        logic   out_free;
    } t_status;

endpackage

@@ rtl/core/rua_datapath.sv @@
// Datapath: tree memory, traversal stack, area accumulator and result register.
module rua_datapath import rua_pkg::*; #(
    parameter int Y_CELLS    = 32768,
    parameter int X_BITS     = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_stat,
    input  logic        s_axis_tvalid,
    input  logic [47:0] s_axis_tdata,   // edge_x, y_bottom, y_top
    input  logic        s_axis_tuser,   // req_type
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // area_so_far, covered_length
    output logic        m_axis_tuser    // order_error
);

    localparam int TREE_CELLS  = (Y_CELLS < 65535) ? Y_CELLS : 65535;
    localparam int NODES       = 4 * TREE_CELLS;
    localparam int ADDR_BITS   = $clog2(NODES);
    localparam int STACK_DEPTH = $clog2(TREE_CELLS) + 1;
    localparam int SIDX_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCNT_BITS   = $clog2(STACK_DEPTH + 1);
    localparam int PROD_BITS   = SPAN_BITS + X_BITS;
    localparam int SUM_BITS    = ((PROD_BITS > 32) ? PROD_BITS : 32) + 1;
    localparam int WORD_BITS   = COUNT_BITS + SPAN_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [ADDR_BITS-1:0] idx;
        logic [SPAN_BITS-1:0] lo;
        logic [SPAN_BITS-1:0] hi;
        t_phase               phase;
    } t_frame;

    logic [WORD_BITS-1:0]  r_mem [NODES];
    logic [WORD_BITS-1:0]  r_rd_data;
    t_frame                r_stack [STACK_DEPTH];
    logic [SCNT_BITS-1:0]  r_sp;
    logic [ADDR_BITS-1:0]  r_clr_addr;
    logic [SPAN_BITS-1:0]  r_y_extent;
    logic [X_BITS-1:0]     r_x;
    logic [X_BITS-1:0]     r_prev_x;
    logic [31:0]           r_area;
    logic                  r_err;
    logic                  r_open;
    logic                  r_range_ok;
    logic [SPAN_BITS-1:0]  r_want_a;
    logic [SPAN_BITS-1:0]  r_want_b;
    logic [PROD_BITS-1:0]  r_prod;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [SPAN_BITS-1:0]  r_llen;
    logic                  r_out_valid;
    logic [31:0]           r_out_area;
    logic [SPAN_BITS-1:0]  r_out_len;
    logic                  r_out_err;

    logic [SPAN_BITS-1:0]  ext_raw;
    logic [SPAN_BITS-1:0]  ext;
    logic [X_BITS-1:0]     in_x;
    logic [SPAN_BITS-1:0]  in_bottom;
    logic [SPAN_BITS-1:0]  in_top;
    logic [SPAN_BITS-1:0]  top_clip;
    t_frame                top;
    logic [SPAN_BITS-1:0]  mid;
    logic [SPAN_BITS-1:0]  span;
    logic [ADDR_BITS-1:0]  left_idx;
    logic [ADDR_BITS-1:0]  right_idx;
    logic                  full;
    logic                  leaf;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [COUNT_BITS-1:0] cnt_upd;
    logic [SPAN_BITS-1:0]  node_len;
    logic [SUM_BITS-1:0]   area_sum;
    logic                  cfg_we;
    logic                  in_take;

    // A cfg write wins over a request offered in the same cycle.
    assign cfg_we  = i_cfg_valid && i_cmd.cfg_open;
    assign in_take = s_axis_tvalid && i_cmd.in_open && !cfg_we;

    // Effective extent: zero acts as one, clip to the tree size.
    always_comb begin
        ext_raw = (r_y_extent == '0) ? SPAN_BITS'(1) : r_y_extent;
        ext     = ext_raw;
        if (32'(ext_raw) > 32'(Y_CELLS)) begin
            ext = SPAN_BITS'(Y_CELLS);
        end
    end

    assign in_x      = X_BITS'(s_axis_tdata[15:0]);
    assign in_bottom = s_axis_tdata[31:16];
    assign in_top    = s_axis_tdata[47:32];
    assign top_clip  = (in_top > ext) ? ext : in_top;

    assign top       = r_stack[SIDX_BITS'(r_sp - 1'b1)];
    assign mid       = top.lo + ((top.hi - top.lo) >> 1);
    assign span      = top.hi - top.lo + 1'b1;
    assign left_idx  = {top.idx[ADDR_BITS-2:0], 1'b0};
    assign right_idx = {top.idx[ADDR_BITS-2:0], 1'b1};
    assign full      = (r_want_a <= top.lo) && (top.hi <= r_want_b);
    assign leaf      = (top.lo == top.hi);

    assign cnt_rd = r_rd_data[WORD_BITS-1:SPAN_BITS];
    always_comb begin
        cnt_upd = cnt_rd;
        if (full) begin
            if (r_open) begin
                if (cnt_rd != COUNT_MAX) cnt_upd = cnt_rd + 1'b1;
            end else begin
                if (cnt_rd != '0) cnt_upd = cnt_rd - 1'b1;
            end
        end
    end

    always_comb begin
        if (r_cnt != '0) begin
            node_len = span;
        end else if (leaf) begin
            node_len = '0;
        end else begin
            node_len = r_llen + r_rd_data[SPAN_BITS-1:0];
        end
    end

    assign area_sum = SUM_BITS'(r_area) + SUM_BITS'(r_prod);

    // Memory port selection.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ADDR_BITS'(1);
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        case (i_cmd.op)
            OP_RD_ROOT: rd_en = 1'b1;
            OP_FIN_RD: begin
                rd_en   = 1'b1;
                rd_addr = top.idx;
            end
            OP_FIN_CNT: begin
                rd_en   = 1'b1;
                rd_addr = left_idx;
            end
            OP_FIN_LLEN: begin
                rd_en   = 1'b1;
                rd_addr = right_idx;
            end
            OP_CLEAR: wr_en = 1'b1;
            OP_FIN_WR: begin
                wr_en   = 1'b1;
                wr_addr = top.idx;
                wr_data = {r_cnt, node_len};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_extent  <= EXTENT_RESET;
            r_clr_addr  <= '0;
            r_prev_x    <= '0;
            r_area      <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_y_extent <= i_cfg_data;
                r_clr_addr <= '0;
            end else if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.op == OP_ADD && !r_err) begin
                r_area   <= (|area_sum[SUM_BITS-1:32]) ? 32'hFFFF_FFFF : area_sum[31:0];
                r_prev_x <= r_x;
            end
            case (i_cmd.op)
                OP_ADD:     r_sp <= r_range_ok ? SCNT_BITS'(1) : '0;
                OP_DESCEND: r_sp <= r_sp + 1'b1;
                OP_POP,
                OP_FIN_WR:  r_sp <= r_sp - 1'b1;
                default: ;
            endcase
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x        <= in_x;
            r_err      <= (in_x < r_prev_x);
            r_open     <= ~s_axis_tuser;
            r_want_a   <= in_bottom + 1'b1;
            r_want_b   <= top_clip;
            r_range_ok <= (top_clip > in_bottom) && (in_bottom < ext);
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= r_rd_data[SPAN_BITS-1:0] * (r_x - r_prev_x);
        end
        if (i_cmd.op == OP_ADD) begin
            r_stack[0] <= '{idx: ADDR_BITS'(1), lo: SPAN_BITS'(1), hi: ext, phase: PH_LEFT};
        end
        if (i_cmd.op == OP_DESCEND) begin
            if (top.phase == PH_LEFT) begin
                r_stack[SIDX_BITS'(r_sp - 1'b1)].phase <= PH_RIGHT;
                r_stack[SIDX_BITS'(r_sp)] <= '{idx: left_idx, lo: top.lo, hi: mid,
                                               phase: PH_LEFT};
            end else begin
                r_stack[SIDX_BITS'(r_sp - 1'b1)].phase <= PH_DONE;
                r_stack[SIDX_BITS'(r_sp)] <= '{idx: right_idx, lo: mid + 1'b1,
                                               hi: top.hi, phase: PH_LEFT};
            end
        end
        if (i_cmd.op == OP_FIN_CNT) begin
            r_cnt <= cnt_upd;
        end
        if (i_cmd.op == OP_FIN_LLEN) begin
            r_llen <= r_rd_data[SPAN_BITS-1:0];
        end
        if (i_cmd.op == OP_OUT) begin
            r_out_area <= r_area;
            r_out_len  <= r_rd_data[SPAN_BITS-1:0];
            r_out_err  <= r_err;
        end
    end

    always_comb begin
        o_stat.cfg_we       = cfg_we;
        o_stat.in_take      = in_take;
        o_stat.clear_last   = (r_clr_addr == ADDR_BITS'(NODES - 1));
        o_stat.range_ok     = r_range_ok;
        o_stat.stack_empty  = (r_sp == '0);
        o_stat.top_phase    = top.phase;
        o_stat.top_full     = full;
        o_stat.top_disjoint = (r_want_b < top.lo) || (r_want_a > top.hi);
        o_stat.out_free     = !r_out_valid || m_axis_tready;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_area};
    assign m_axis_tuser  = r_out_err;

endmodule

@@ rtl/core/rua_ctrl.sv @@
// Controller: sequences clearing, area update and the tree traversal.
module rua_ctrl import rua_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_stat,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT_RD,
        S_MUL,
        S_ADD,
        S_VISIT,
        S_FIN_RD,
        S_FIN_CNT,
        S_FIN_LLEN,
        S_FIN_WR,
        S_END_RD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.in_open  = 1'b0;
        o_cmd.cfg_open = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op       = OP_CLEAR;
                o_cmd.cfg_open = 1'b1;
                if (!i_stat.cfg_we && i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_open  = 1'b1;
                o_cmd.cfg_open = 1'b1;
                if (i_stat.cfg_we) begin
                    n_state = S_CLEAR;
                end else if (i_stat.in_take) begin
                    n_state = S_ROOT_RD;
                end
            end
            S_ROOT_RD: begin
                o_cmd.op = OP_RD_ROOT;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = i_stat.range_ok ? S_VISIT : S_END_RD;
            end
            S_VISIT: begin
                if (i_stat.stack_empty) begin
                    n_state = S_END_RD;
                end else if (i_stat.top_phase == PH_DONE) begin
                    n_state = S_FIN_RD;
                end else if (i_stat.top_phase == PH_RIGHT) begin
                    o_cmd.op = OP_DESCEND;
                end else if (i_stat.top_disjoint) begin
                    o_cmd.op = OP_POP;
                end else if (i_stat.top_full) begin
                    n_state = S_FIN_RD;
                end else begin
                    o_cmd.op = OP_DESCEND;
                end
            end
            S_FIN_RD: begin
                o_cmd.op = OP_FIN_RD;
                n_state  = S_FIN_CNT;
            end
            S_FIN_CNT: begin
                o_cmd.op = OP_FIN_CNT;
                n_state  = S_FIN_LLEN;
            end
            S_FIN_LLEN: begin
                o_cmd.op = OP_FIN_LLEN;
                n_state  = S_FIN_WR;
            end
            S_FIN_WR: begin
                o_cmd.op = OP_FIN_WR;
                n_state  = S_VISIT;
            end
            S_END_RD: begin
                o_cmd.op = OP_RD_ROOT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/rectangle_union_area_sweep.sv @@
// Top level of the rectangle union area sweep.
// Usage:
//   s_axis carries one rectangle edge per request: tdata holds edge_x [15:0],
//   y_bottom [31:16] and y_top [47:32]; tuser is req_type (0 opens, 1 closes).
//   m_axis returns one result per request: tdata holds area_so_far [31:0] and
//   covered_length [47:32]; tuser is order_error.
//   The cfg channel writes y_extent; a write clears the whole tree but keeps
//   the running area and the previous x. A write offered beside a request wins.
// Sequence:
//   A taken request adds root length times the x step to the area (not on an order
//   error), then walks the tree: a node outside the range is popped, a covered one is
//   updated, a partly covered one updated after both halves; the root gives the result.
// Reset and clearing:
//   After reset, and after every cfg write, the tree memory is swept to zero,
//   one node a cycle, all 4 * Y_CELLS nodes (131072 at the default). No request
//   is taken meanwhile; cfg writes still are, and restart the sweep.
// Back-pressure:
//   The result waits in an output register and the next request is taken meanwhile;
//   that request's result holds the block until m_axis has taken the one before.
module rectangle_union_area_sweep import rua_pkg::*; #(
    parameter int Y_CELLS    = 32768,
    parameter int X_BITS     = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // edge_x, y_bottom, y_top
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // area_so_far, covered_length
    output logic        m_axis_tuser,   // order_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // y_extent
);

    t_cmd    cmd;
    t_status stat;

    rua_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rua_datapath #(
        .Y_CELLS    (Y_CELLS),
        .X_BITS     (X_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Accept requests and cfg writes only when the controller opens them;
    // hold off a request while a cfg write is being taken.
    assign s_axis_tready = cmd.in_open && !(i_cfg_valid && cmd.cfg_open);
    assign o_cfg_ready   = cmd.cfg_open;

endmodule

@@ verif/rua_sweep_checker.sv @@
// Checker for the rectangle union area sweep: predicts each result and compares it.
`timescale 1ns / 100ps

module rua_sweep_checker import rua_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NODES     = 4 * 32768;
    localparam int CELLS     = 32768;
    localparam int COUNT_TOP = 65535;

    typedef struct {
        logic [31:0] area;
        logic [15:0] cov_len;
        logic        order_err;
    } t_sweep_result;

    int unsigned    node_count [NODES];
    int unsigned    node_len   [NODES];
    logic [15:0]    extent_reg;
    logic [15:0]    last_x;
    logic [31:0]    area_acc;
    t_sweep_result  area_queue [$];

    function automatic void clear_tree();
        for (int i = 0; i < NODES; i++) begin
            node_count[i] = 0;
            node_len[i]   = 0;
        end
    endfunction

    // Walk the tree, add or remove one cover on fully inside nodes, refresh lengths.
    function automatic void update_cover(int unsigned idx, int unsigned lo, int unsigned hi,
                                         int unsigned a, int unsigned b, bit opening);
        int unsigned mid;
        if (idx >= NODES) return;
        if (b < lo || a > hi) return;
        if (a <= lo && hi <= b) begin
            if (opening && node_count[idx] < COUNT_TOP) node_count[idx]++;
            if (!opening && node_count[idx] > 0) node_count[idx]--;
        end else begin
            mid = lo + (hi - lo) / 2;
            update_cover(idx * 2, lo, mid, a, b, opening);
            update_cover(idx * 2 + 1, mid + 1, hi, a, b, opening);
        end
        if (node_count[idx] != 0)
            node_len[idx] = hi - lo + 1;
        else if (lo == hi || idx * 2 + 1 >= NODES)
            node_len[idx] = 0;
        else
            node_len[idx] = node_len[idx * 2] + node_len[idx * 2 + 1];
    endfunction

    function automatic t_sweep_result predict_area(logic req_close, logic [15:0] x,
                                                   logic [15:0] bot, logic [15:0] top_in);
        t_sweep_result r;
        int unsigned   ext;
        int unsigned   top;
        longint unsigned sum;
        ext = (extent_reg == 0) ? 1 : extent_reg;
        if (ext > CELLS) ext = CELLS;
        r.order_err = 1'b0;
        if (x < last_x) begin
            r.order_err = 1'b1;
        end else begin
            sum = longint'(area_acc) + longint'(node_len[1]) * longint'(x - last_x);
            area_acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            last_x   = x;
        end
        top = (top_in > ext) ? ext : top_in;
        if (top > bot && bot < ext)
            update_cover(1, 1, ext, bot + 1, top, !req_close);
        r.area    = area_acc;
        r.cov_len = (node_len[1] > 65535) ? 16'hFFFF : node_len[1][15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sweep_result want;
        if (!i_rst_n) begin
            if (extent_reg !== EXTENT_RESET || area_acc !== 0) clear_tree();
            extent_reg = EXTENT_RESET;
            last_x     = '0;
            area_acc   = '0;
            area_queue.delete();
        end else begin
            // Drain before accepting, so a same-edge request never races its result.
            if (m_axis_tvalid && m_axis_tready) begin
                if (area_queue.size() == 0) begin
                    $display("%0t: unexpected result area %0d len %0d err %0b", $time,
                             m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tuser);
                    o_fail_count++;
                end else begin
                    want = area_queue.pop_front();
                    if (m_axis_tdata[31:0] !== want.area) begin
                        $display("%0t: area expected %0d actual %0d", $time,
                                 want.area, m_axis_tdata[31:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[47:32] !== want.cov_len) begin
                        $display("%0t: covered length expected %0d actual %0d", $time,
                                 want.cov_len, m_axis_tdata[47:32]);
                        o_fail_count++;
                    end
                    if (m_axis_tuser !== want.order_err) begin
                        $display("%0t: order error expected %0b actual %0b", $time,
                                 want.order_err, m_axis_tuser);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                extent_reg = i_cfg_data;
                clear_tree();
            end
            if (s_axis_tvalid && s_axis_tready)
                area_queue.push_back(predict_area(s_axis_tuser, s_axis_tdata[15:0],
                                                  s_axis_tdata[31:16], s_axis_tdata[47:32]));
        end
        o_pending = area_queue.size();
    end

endmodule

@@ verif/rectangle_union_area_sweep_tb.sv @@
// Stimulus and verdict for the rectangle union area sweep regression.
`timescale 1ns / 100ps

module rectangle_union_area_sweep_tb import rua_pkg::*;;

    localparam logic REQ_OPEN  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // edge_x, y_bottom, y_top
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // area_so_far, covered_length
    logic        m_axis_tuser;   // order_error
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;     // y_extent
    int          fail_count;
    int          pending;

    // Idling knobs, in percent of cycles.
    int          send_idle_pct;
    int          recv_stall_pct;
    // Sweep position; only forward moves update it.
    logic [15:0] sweep_x;
    logic [15:0] cur_extent;

    typedef struct {
        logic [15:0] bot;
        logic [15:0] top;
    } t_rect;
    t_rect open_rects [$];

    rectangle_union_area_sweep dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    rua_sweep_checker checker_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Stall the result side at random, one fresh draw per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one edge request; idle first at random, hold it until accepted.
    task automatic send_edge(logic kind, logic [15:0] x, logic [15:0] bot, logic [15:0] top);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {top, bot, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait on the falling edge so the checker's count is settled.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Write the extent only with the block idle; the write restarts its clearing sweep.
    task automatic write_extent(logic [15:0] value);
        drain_results();
        repeat (150) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_extent = value;
        open_rects.delete();
    endtask

    // Mostly matched open/close pairs over the current extent, plus noise.
    task automatic random_edges(int count);
        int          pick;
        int unsigned span;
        logic [15:0] x;
        t_rect       r;
        for (int n = 0; n < count; n++) begin
            sweep_x = sweep_x + 16'($urandom_range(0, 18));
            x = sweep_x;
            if ($urandom_range(99) < 4 && sweep_x > 0)
                x = sweep_x - 16'($urandom_range(1, sweep_x));   // step x backwards
            pick = $urandom_range(99);
            if (pick < 45 && open_rects.size() < 40) begin
                r.bot = 16'($urandom_range(0, cur_extent - 1));
                span  = (cur_extent > 64 && $urandom_range(3) != 0) ? 64 : cur_extent;
                r.top = r.bot + 16'($urandom_range(1, span));
                if (r.top > cur_extent) r.top = cur_extent;
                open_rects.push_back(r);
                send_edge(REQ_OPEN, x, r.bot, r.top);
            end else if (pick < 88 && open_rects.size() != 0) begin
                span = $urandom_range(0, open_rects.size() - 1);
                r = open_rects[span];
                open_rects.delete(span);
                send_edge(REQ_CLOSE, x, r.bot, r.top);
            end else begin
                // Raw fields: unmatched closes, clipped or empty ranges, any bit pattern.
                send_edge(logic'($urandom_range(1)), x, 16'($urandom_range(65535)),
                          16'($urandom_range(65535)));
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= REQ_OPEN;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sweep_x        = '0;
        cur_extent     = EXTENT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed edges at the reset extent.
        send_edge(REQ_OPEN,  16'd0,  16'd0,     16'd32768);   // whole column
        send_edge(REQ_CLOSE, 16'd10, 16'd0,     16'd32768);
        send_edge(REQ_CLOSE, 16'd10, 16'd0,     16'd32768);   // unmatched close
        send_edge(REQ_OPEN,  16'd20, 16'd7,     16'd7);       // empty range
        send_edge(REQ_OPEN,  16'd20, 16'd100,   16'd5);       // top below bottom
        send_edge(REQ_OPEN,  16'd21, 16'd32768, 16'd32768);   // bottom at extent
        send_edge(REQ_OPEN,  16'd22, 16'hFFFF,  16'hFFFF);    // bottom past extent
        send_edge(REQ_OPEN,  16'd30, 16'd32767, 16'hFFFF);    // top clipped
        send_edge(REQ_OPEN,  16'd31, 16'd0,     16'd1);       // lowest cell
        send_edge(REQ_OPEN,  16'd31, 16'd5,     16'd300);
        send_edge(REQ_OPEN,  16'd5,  16'd1,     16'd4);       // x goes backwards
        send_edge(REQ_CLOSE, 16'd0,  16'd5,     16'd300);     // backwards to zero
        send_edge(REQ_CLOSE, 16'd40, 16'd1,     16'd4);
        send_edge(REQ_CLOSE, 16'd44, 16'd0,     16'd1);
        send_edge(REQ_CLOSE, 16'd50, 16'd32767, 16'hFFFF);
        send_edge(REQ_CLOSE, 16'd50, 16'd5,     16'd300);
        sweep_x = 16'd50;

        // Smallest extent, no idling.
        write_extent(16'd1);
        random_edges(250);
        // Odd small extent, sender mostly idle.
        write_extent(16'd37);
        send_idle_pct = 72;
        random_edges(350);
        // Largest extent, receiver mostly stalled; pause once until all results are in.
        write_extent(16'd32768);
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        random_edges(180);
        drain_results();
        random_edges(170);
        // Mid extent, both sides idling now and then.
        write_extent(16'd1000);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        random_edges(350);
        // Zero acts as the smallest extent.
        write_extent(16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_edges(300);
        // Top of the x range, then a step back from it.
        send_edge(REQ_OPEN,  16'hFFFF, 16'd0, 16'd1);
        send_edge(REQ_CLOSE, 16'h7FFF, 16'd0, 16'd1);
        send_edge(REQ_CLOSE, 16'hFFFF, 16'd0, 16'd1);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("rectangle_union_area_sweep regression: pass");
        else
            $display("rectangle_union_area_sweep regression: fail");
        $finish;
    end

    // Hard stop well past the slowest correct run, clearing sweeps included.
    initial begin
        #64_000_000;
        $display("rectangle_union_area_sweep regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rua_pkg.sv
rtl/core/rua_datapath.sv
rtl/core/rua_ctrl.sv
rtl/core/rectangle_union_area_sweep.sv
verif/rua_sweep_checker.sv
verif/rectangle_union_area_sweep_tb.sv
